### rtl/aes_pkg.sv
// Package with AES-128 constants, substitution tables and round functions.
`default_nettype none
package aes_pkg;

    localparam int RoundCount = 10;
    localparam int KeyWords = 4 * (RoundCount + 1);
    localparam int KeyIdxW = $clog2(KeyWords);
    localparam int RoundW = $clog2(RoundCount + 1);

    localparam logic [0:0] FUNC_ENCRYPT = 1'b0;
    localparam logic [0:0] FUNC_DECRYPT = 1'b1;

    localparam logic [0:0] REG_KEY_HIGH = 1'b0;
    localparam logic [0:0] REG_KEY_LOW = 1'b1;

    typedef logic [7:0] byte_t;
    typedef logic [127:0] block_t;

    localparam byte_t [0:255] FwdBox = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam byte_t [0:255] InvBox = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic byte_t xt(input byte_t x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic byte_t get_byte(input block_t s, input int idx);
        return s[127 - 8 * idx -: 8];
    endfunction

    function automatic block_t sub_bytes(input block_t s, input logic inv);
        block_t o;
        for (int i = 0; i < 16; i++)
        begin
            o[127 - 8 * i -: 8] = inv ? InvBox[get_byte(s, i)] : FwdBox[get_byte(s, i)];
        end
        return o;
    endfunction

    function automatic block_t shift_rows(input block_t s, input logic inv);
        block_t o;
        int src;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                src = inv ? ((c + 4 - r) % 4) : ((c + r) % 4);
                o[127 - 8 * (4 * c + r) -: 8] = get_byte(s, 4 * src + r);
            end
        end
        return o;
    endfunction

    function automatic block_t mix_columns(input block_t s, input logic inv);
        block_t o;
        byte_t a0, a1, a2, a3, b0, b1, b2, b3, u, v;
        for (int c = 0; c < 4; c++)
        begin
            a0 = get_byte(s, 4 * c);
            a1 = get_byte(s, 4 * c + 1);
            a2 = get_byte(s, 4 * c + 2);
            a3 = get_byte(s, 4 * c + 3);
            if (inv)
            begin
                // Pre-multiply so the forward matrix yields the inverse one.
                u = xt(xt(a0 ^ a2));
                v = xt(xt(a1 ^ a3));
                a0 = a0 ^ u;
                a1 = a1 ^ v;
                a2 = a2 ^ u;
                a3 = a3 ^ v;
            end
            b0 = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
            b1 = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
            b2 = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
            b3 = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
            o[127 - 32 * c -: 32] = {b0, b1, b2, b3};
        end
        return o;
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {FwdBox[w[31:24]], FwdBox[w[23:16]], FwdBox[w[15:8]], FwdBox[w[7:0]]};
    endfunction

endpackage
`default_nettype wire

### rtl/aes128_block_cipher.sv
// AES-128 block cipher top level: key schedule, iterative round unit and ports.
// A block passes through the initial key addition and ten rounds, each of which
// gathers four round-key words from the store, one per cycle.
// After reset or a key write the next block first expands the key into the store.
// A new block is accepted only after the previous result beat has been taken.
// Reset (rst_n, asynchronous) clears all registers except the round-key store and its read register rk_rd_reg.
`default_nettype none
module aes128_block_cipher
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [63:0]  pwdata,
    output logic      [63:0]  prdata,
    output logic              pready,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // tdata: block_high [63:0], block_low [127:64]
    input  wire logic [127:0] s_tdata,
    // tuser: func
    input  wire logic [0:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // tdata: result_high [63:0], result_low [127:64]
    output logic      [127:0] m_tdata
);
    import aes_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXPAND = 2'd1;
    localparam logic [1:0] ST_ROUND = 2'd2;
    localparam logic [1:0] ST_OUT = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [63:0] key_high_reg, key_low_reg;
    logic keys_valid_reg;
    logic [31:0] rk_mem [0:KeyWords-1];
    logic [KeyIdxW-1:0] widx_reg;
    logic [31:0] w1_reg, w2_reg, w3_reg, w4_reg;
    byte_t rcon_reg;
    logic [RoundW-1:0] rnd_reg;
    logic [1:0] col_reg;
    logic func_reg;
    block_t state_blk_reg, in_blk_reg;
    logic [95:0] rk_reg;
    logic [31:0] rk_rd_reg;
    logic loading_reg;
    logic cfg_wr;
    logic [31:0] t_word, new_word;
    logic [31:0] key_word;
    logic seed_word;
    logic [127:0] rk_key;
    block_t rnd_out;
    logic last_round;
    logic [RoundW-1:0] rd_rnd;
    logic [1:0] rd_col;
    logic [KeyIdxW-1:0] ridx;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[3] == REG_KEY_LOW) ? key_low_reg : key_high_reg;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata = {state_blk_reg[63:0], state_blk_reg[127:64]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg <= '0;
        end
        else if (cfg_wr && paddr[2:0] == 3'd0 && paddr[3] == REG_KEY_HIGH)
        begin
            key_high_reg <= pwdata;
        end
        else if (cfg_wr && paddr[2:0] == 3'd0 && paddr[3] == REG_KEY_LOW)
        begin
            key_low_reg <= pwdata;
        end
    end

    // Key expansion: one word per cycle, the first four taken from the key registers,
    // the rest from a four-word sliding window.
    assign seed_word = (widx_reg < KeyIdxW'(4));

    always_comb
    begin
        case (widx_reg[1:0])
            2'd0: key_word = key_high_reg[63:32];
            2'd1: key_word = key_high_reg[31:0];
            2'd2: key_word = key_low_reg[63:32];
            default: key_word = key_low_reg[31:0];
        endcase
    end

    assign t_word = (widx_reg[1:0] == 2'd0)
        ? (sub_word({w4_reg[23:0], w4_reg[31:24]}) ^ {rcon_reg, 24'd0}) : w4_reg;
    assign new_word = w1_reg ^ t_word;

    // Round key read: one word per cycle, four words gathered per round.
    assign last_round = (func_reg == FUNC_ENCRYPT) ? (rnd_reg == RoundW'(RoundCount))
                                                   : (rnd_reg == '0);
    assign rk_key = {rk_reg, rk_rd_reg};

    always_comb
    begin
        block_t t;
        t = state_blk_reg;
        if (func_reg == FUNC_ENCRYPT)
        begin
            t = shift_rows(sub_bytes(t, 1'b0), 1'b0);
            if (!last_round)
            begin
                t = mix_columns(t, 1'b0);
            end
            t = t ^ rk_key;
        end
        else
        begin
            t = sub_bytes(shift_rows(t, 1'b1), 1'b1) ^ rk_key;
            if (!last_round)
            begin
                t = mix_columns(t, 1'b1);
            end
        end
        rnd_out = t;
    end

    // The store read is registered, so the address is the one for the next cycle.
    always_comb
    begin
        rd_rnd = rnd_reg;
        rd_col = col_reg;
        if (state_reg == ST_IDLE)
        begin
            rd_rnd = (s_tuser[0] == FUNC_ENCRYPT) ? '0 : RoundW'(RoundCount);
            rd_col = 2'd0;
        end
        else if (state_reg == ST_ROUND)
        begin
            rd_col = col_reg + 2'd1;
            if (col_reg == 2'd3 && !last_round)
            begin
                rd_rnd = (func_reg == FUNC_ENCRYPT) ? rnd_reg + 1'b1 : rnd_reg - 1'b1;
            end
        end
    end

    assign ridx = KeyIdxW'({rd_rnd, rd_col});

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EXPAND)
        begin
            rk_mem[widx_reg] <= seed_word ? key_word : new_word;
        end
        rk_rd_reg <= rk_mem[ridx];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = keys_valid_reg ? ST_ROUND : ST_EXPAND;
                end
            end
            ST_EXPAND:
            begin
                if (widx_reg == KeyIdxW'(KeyWords - 1))
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (col_reg == 2'd3 && !loading_reg && last_round)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // In ST_ROUND, loading_reg marks the first pass that only fetches the
    // initial round key; col_reg walks the four key words of each round and
    // the round unit fires when the fourth word arrives.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            keys_valid_reg <= 1'b0;
            widx_reg <= '0;
            rnd_reg <= '0;
            col_reg <= '0;
            loading_reg <= 1'b0;
            func_reg <= FUNC_ENCRYPT;
            rcon_reg <= 8'h01;
            in_blk_reg <= '0;
            state_blk_reg <= '0;
            rk_reg <= '0;
            w1_reg <= '0;
            w2_reg <= '0;
            w3_reg <= '0;
            w4_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr)
            begin
                keys_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        func_reg <= s_tuser[0];
                        in_blk_reg <= {s_tdata[63:0], s_tdata[127:64]};
                        widx_reg <= '0;
                        rcon_reg <= 8'h01;
                        w1_reg <= key_high_reg[63:32];
                        w2_reg <= key_high_reg[31:0];
                        w3_reg <= key_low_reg[63:32];
                        w4_reg <= key_low_reg[31:0];
                        rnd_reg <= (s_tuser[0] == FUNC_ENCRYPT) ? '0 : RoundW'(RoundCount);
                        col_reg <= '0;
                        loading_reg <= 1'b1;
                    end
                end
                ST_EXPAND:
                begin
                    widx_reg <= widx_reg + 1'b1;
                    if (!seed_word)
                    begin
                        {w1_reg, w2_reg, w3_reg, w4_reg} <= {w2_reg, w3_reg, w4_reg, new_word};
                        if (widx_reg[1:0] == 2'd0)
                        begin
                            rcon_reg <= xt(rcon_reg);
                        end
                    end
                    if (widx_reg == KeyIdxW'(KeyWords - 1))
                    begin
                        keys_valid_reg <= 1'b1;
                    end
                end
                ST_ROUND:
                begin
                    col_reg <= col_reg + 1'b1;
                    rk_reg <= {rk_reg[63:0], rk_rd_reg};
                    if (col_reg == 2'd3)
                    begin
                        if (loading_reg)
                        begin
                            state_blk_reg <= in_blk_reg ^ rk_key;
                            loading_reg <= 1'b0;
                        end
                        else
                        begin
                            state_blk_reg <= rnd_out;
                        end
                        rnd_reg <= (func_reg == FUNC_ENCRYPT) ? rnd_reg + 1'b1
                                                               : rnd_reg - 1'b1;
                    end
                end
                ST_OUT:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("Result changed while stalled.");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXPAND) |-> !s_tready)
        else $error("Input accepted during key expansion.");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXPAND && state_next == ST_ROUND) |=> keys_valid_reg)
        else $error("Key store not marked valid after expansion.");

endmodule
`default_nettype wire

### sim/aes128_block_cipher_tb.sv
// Testbench for the AES-128 block cipher: random and directed blocks checked against a local model.
`default_nettype none
module aes128_block_cipher_tb;
    import aes_pkg::*;

    typedef struct packed
    {
        logic [63:0] hi;
        logic [63:0] lo;
    } blk_t;

    class cipher_scoreboard;
        blk_t pending[$];
        int errors;
        int checked;

        function void note_block(blk_t r);
            pending.push_back(r);
        endfunction

        function void check_block(logic [127:0] tdata);
            blk_t want;
            if (pending.size() == 0)
            begin
                $error("result beat with no block outstanding: %h", tdata);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (tdata[63:0] !== want.hi)
            begin
                $error("result_high expected %h actual %h", want.hi, tdata[63:0]);
                errors++;
            end
            if (tdata[127:64] !== want.lo)
            begin
                $error("result_low expected %h actual %h", want.lo, tdata[127:64]);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic pready;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [127:0] s_tdata = '0;
    logic [0:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [127:0] m_tdata;

    cipher_scoreboard board;
    logic [63:0] key_hi, key_lo;
    logic [31:0] sched[KeyWords];
    int blocks_sent;
    int enc_count, dec_count;
    bit sending_done;

    aes128_block_cipher dut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #200_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic byte_t gf_mul(byte_t x, int y);
        byte_t acc;
        acc = 8'h00;
        while (y != 0)
        begin
            if (y & 1) acc ^= x;
            x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
            y >>= 1;
        end
        return acc;
    endfunction

    function automatic void build_schedule();
        logic [31:0] t;
        byte_t rc;
        rc = 8'h01;
        sched[0] = key_hi[63:32];
        sched[1] = key_hi[31:0];
        sched[2] = key_lo[63:32];
        sched[3] = key_lo[31:0];
        for (int i = 4; i < KeyWords; i++)
        begin
            t = sched[i - 1];
            if (i % 4 == 0)
            begin
                t = {t[23:0], t[31:24]};
                t = {FwdBox[t[31:24]], FwdBox[t[23:16]], FwdBox[t[15:8]], FwdBox[t[7:0]]};
                t ^= {rc, 24'h0};
                rc = gf_mul(rc, 2);
            end
            sched[i] = sched[i - 4] ^ t;
        end
    endfunction

    function automatic blk_t cipher_block(logic decrypt, blk_t in);
        byte_t st[16], tmp[16], a[4];
        int m[4], src;
        blk_t out;
        for (int i = 0; i < 8; i++)
        begin
            st[i] = in.hi[63 - 8 * i -: 8];
            st[i + 8] = in.lo[63 - 8 * i -: 8];
        end
        for (int step = 0; step <= RoundCount; step++)
        begin
            int rnd;
            rnd = decrypt ? RoundCount - step : step;
            if (step > 0)
            begin
                if (!decrypt)
                    for (int i = 0; i < 16; i++) st[i] = FwdBox[st[i]];
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                    begin
                        src = decrypt ? (c + 4 - r) % 4 : (c + r) % 4;
                        tmp[4 * c + r] = st[4 * src + r];
                    end
                st = tmp;
                if (decrypt)
                    for (int i = 0; i < 16; i++) st[i] = InvBox[st[i]];
                if (!decrypt && step < RoundCount)
                begin
                    m = '{2, 3, 1, 1};
                    for (int c = 0; c < 4; c++)
                    begin
                        for (int k = 0; k < 4; k++) a[k] = st[4 * c + k];
                        for (int r = 0; r < 4; r++)
                        begin
                            st[4 * c + r] = 8'h00;
                            for (int k = 0; k < 4; k++)
                                st[4 * c + r] ^= gf_mul(a[k], m[(k + 4 - r) % 4]);
                        end
                    end
                end
            end
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    st[4 * c + r] ^= sched[4 * rnd + c][31 - 8 * r -: 8];
            if (decrypt && step > 0 && step < RoundCount)
            begin
                m = '{14, 11, 13, 9};
                for (int c = 0; c < 4; c++)
                begin
                    for (int k = 0; k < 4; k++) a[k] = st[4 * c + k];
                    for (int r = 0; r < 4; r++)
                    begin
                        st[4 * c + r] = 8'h00;
                        for (int k = 0; k < 4; k++)
                            st[4 * c + r] ^= gf_mul(a[k], m[(k + 4 - r) % 4]);
                    end
                end
            end
        end
        for (int i = 0; i < 8; i++)
        begin
            out.hi[63 - 8 * i -: 8] = st[i];
            out.lo[63 - 8 * i -: 8] = st[i + 8];
        end
        return out;
    endfunction

    task automatic write_key(logic [0:0] idx, logic [63:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 4'(idx) << 3;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_KEY_HIGH) key_hi = value;
        else key_lo = value;
        build_schedule();
    endtask

    task automatic send_block(logic decrypt, logic [63:0] hi, logic [63:0] lo, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= decrypt;
        s_tdata <= {lo, hi};
        do @(posedge clk); while (!s_tready);
        board.note_block(cipher_block(decrypt, '{hi: hi, lo: lo}));
        if (decrypt == FUNC_DECRYPT) dec_count++;
        else enc_count++;
        blocks_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] pick_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return rand64();
        endcase
    endfunction

    // Result side: random stall before each beat, with calm stretches.
    initial
    begin
        int stall;
        bit calm;
        @(posedge rst_n);
        forever
        begin
            calm = ($urandom_range(0, 3) == 0);
            stall = calm ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            board.check_block(m_tdata);
        end
    end

    initial
    begin
        logic [63:0] hi, lo;
        board = new();
        key_hi = '0;
        key_lo = '0;
        build_schedule();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Blocks under the reset key, before any key write.
        send_block(FUNC_ENCRYPT, '0, '0, 0);
        send_block(FUNC_DECRYPT, '0, '0, 0);
        send_block(FUNC_ENCRYPT, '1, '1, 0);
        drain();

        // Standard test vector key, then extremes.
        write_key(REG_KEY_HIGH, 64'h0001020304050607);
        write_key(REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
        send_block(FUNC_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff, 0);
        send_block(FUNC_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 0);
        send_block(FUNC_DECRYPT, '1, '0, 0);
        send_block(FUNC_ENCRYPT, '0, '1, 0);
        drain();
        write_key(REG_KEY_HIGH, '1);
        write_key(REG_KEY_LOW, '1);
        send_block(FUNC_ENCRYPT, '1, '1, 0);
        send_block(FUNC_DECRYPT, '1, '1, 0);
        send_block(FUNC_ENCRYPT, 64'h8000000000000000, 64'h1, 0);
        drain();
        // Only the low half changes: the schedule must be rebuilt.
        write_key(REG_KEY_LOW, '0);
        send_block(FUNC_DECRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210, 0);
        send_block(FUNC_ENCRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210, 0);
        drain();

        for (int phase = 0; phase < 11; phase++)
        begin
            if (phase % 2 == 0) write_key(REG_KEY_HIGH, pick_word());
            if (phase % 3 != 1) write_key(REG_KEY_LOW, pick_word());
            for (int n = 0; n < 150; n++)
            begin
                hi = ($urandom_range(0, 9) == 0) ? pick_word() : rand64();
                lo = ($urandom_range(0, 9) == 0) ? pick_word() : rand64();
                send_block(1'($urandom_range(0, 1)), hi, lo, (phase % 4) != 3);
                if (n == 75) drain();
            end
            drain();
        end
        sending_done = 1;
    end

    initial
    begin
        int waited;
        wait (sending_done);
        waited = 0;
        while (board.pending.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (40) @(posedge clk);
        $display("Sent %0d blocks (%0d encrypt, %0d decrypt) over 13 key settings.",
                 blocks_sent, enc_count, dec_count);
        $display("Checked %0d result beats, %0d left outstanding.",
                 board.checked, board.pending.size());
        if (board.errors == 0 && board.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire

### filelist.f
rtl/aes_pkg.sv
rtl/aes128_block_cipher.sv
sim/aes128_block_cipher_tb.sv
